// ===== hdl/wam_pkg.sv =====
package wam_pkg;

    localparam int SMP_W      = 16;
    localparam int WGT_W      = 17;   // unsigned Q1.16, 1.0 kept as 65536
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 18;
    localparam int PROD_W     = SMP_W + WGT_W + 1;
    localparam int SUM_W      = PROD_W + 1;
    localparam int CNT_W      = 3;
    localparam int RATIO_W    = 8;
    localparam int MASK_W     = 4;
    localparam int FIELDS     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_COUNT = 2'd0,
        CFG_MIX_RATIO    = 2'd1,
        CFG_PAUSE_MASK   = 2'd2
    } t_cfg_idx;

    // Weight of one slot. Crossfade: floor(part*65536/255) = part*257 + (part==255).
    function automatic logic [WGT_W-1:0] wam_weight(
        input logic [CNT_W-1:0]   cnt,
        input logic [RATIO_W-1:0] ratio,
        input logic               slot_one
    );
        logic [RATIO_W-1:0] part;
        logic [WGT_W-1:0]   w;
        part = slot_one ? ratio : ~ratio;
        case (cnt)
            3'd1:    w = WGT_W'(65536);
            3'd2:    w = WGT_W'(part) * WGT_W'(257) + WGT_W'(part == 8'hFF);
            3'd3:    w = WGT_W'(21845);
            3'd4:    w = WGT_W'(16384);
            3'd5:    w = WGT_W'(13107);
            3'd6:    w = WGT_W'(10922);
            3'd7:    w = WGT_W'(9362);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/weighted_audio_mixer_top.sv =====
// Weighted audio mixer. Takes one item per clock while the pipeline is not stalled
// (four signed 16-bit samples plus a present mask) and returns one saturated mixed
// sample per item, in order. Each slot owns one cell of two stages (multiply by its
// weight, then accumulate with truncation toward zero), followed by a saturating
// output register; throughput is one item per cycle while the output is not stalled.
// Backpressure ripples through per-stage ready, so bubbles close up while the output
// is stalled. Configuration writes (source_count, mix_ratio, pause_mask) take effect
// on the next item and must only be made while no item is in flight.
module weighted_audio_mixer_top #(
    parameter int MAX_SOURCES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wam_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wam_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [wam_pkg::SMP_W-1:0]     i_sample_a,
    input  logic signed [wam_pkg::SMP_W-1:0]     i_sample_b,
    input  logic signed [wam_pkg::SMP_W-1:0]     i_sample_c,
    input  logic signed [wam_pkg::SMP_W-1:0]     i_sample_d,
    input  logic [wam_pkg::MASK_W-1:0]           i_present_mask,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [wam_pkg::SMP_W-1:0]     o_mixed_sample
);
    import wam_pkg::*;

    localparam int NUM_SLOTS = (MAX_SOURCES < FIELDS) ? MAX_SOURCES : FIELDS;

    logic [CNT_W-1:0]   r_count;
    logic [RATIO_W-1:0] r_ratio;
    logic [MASK_W-1:0]  r_pause;

    logic [FIELDS-1:0][SMP_W-1:0]    w_fields;
    logic [NUM_SLOTS-1:0][WGT_W-1:0] w_weight;

    logic                            c_vld [NUM_SLOTS+1];
    logic                            c_rdy [NUM_SLOTS+1];
    logic signed [ACC_W-1:0]         c_acc [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0][SMP_W-1:0] c_smp [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0]            c_en  [NUM_SLOTS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ratio <= '0;
            r_pause <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SOURCE_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                CFG_MIX_RATIO:    r_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_PAUSE_MASK:   r_pause <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_fields = {i_sample_d, i_sample_c, i_sample_b, i_sample_a};

    assign c_vld[0]   = i_in_valid;
    assign o_in_ready = c_rdy[0];
    assign c_acc[0]   = '0;
    assign c_smp[0]   = w_fields[NUM_SLOTS-1:0];

    for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_slot
        // slot counts only if attached, present and not paused
        assign c_en[0][j] = i_present_mask[j] && !r_pause[j] && (CNT_W'(j) < r_count);
        assign w_weight[j] = wam_weight(r_count, r_ratio, j == 1);

        wam_cell #(
            .NUM_SLOTS (NUM_SLOTS),
            .SLOT      (j)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_weight (w_weight[j]),
            .i_valid  (c_vld[j]),
            .o_ready  (c_rdy[j]),
            .i_acc    (c_acc[j]),
            .i_smp    (c_smp[j]),
            .i_en     (c_en[j]),
            .o_valid  (c_vld[j+1]),
            .i_ready  (c_rdy[j+1]),
            .o_acc    (c_acc[j+1]),
            .o_smp    (c_smp[j+1]),
            .o_en     (c_en[j+1])
        );
    end

    wam_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_vld[NUM_SLOTS]),
        .o_ready (c_rdy[NUM_SLOTS]),
        .i_acc   (c_acc[NUM_SLOTS]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_mixed_sample)
    );

endmodule

// ===== hdl/wam_cell.sv =====
module wam_cell #(
    parameter int NUM_SLOTS = 4,
    parameter int SLOT      = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [wam_pkg::WGT_W-1:0]              i_weight,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [wam_pkg::ACC_W-1:0]       i_acc,
    input  logic [NUM_SLOTS-1:0][wam_pkg::SMP_W-1:0] i_smp,
    input  logic [NUM_SLOTS-1:0]                   i_en,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [wam_pkg::ACC_W-1:0]       o_acc,
    output logic [NUM_SLOTS-1:0][wam_pkg::SMP_W-1:0] o_smp,
    output logic [NUM_SLOTS-1:0]                   o_en
);
    import wam_pkg::*;

    // stage A: product of this slot
    logic                           r_a_vld;
    logic signed [ACC_W-1:0]        r_a_acc;
    logic signed [PROD_W-1:0]       r_a_prod;
    logic [NUM_SLOTS-1:0][SMP_W-1:0] r_a_smp;
    logic [NUM_SLOTS-1:0]           r_a_en;
    // stage B: accumulate, truncate toward zero
    logic                           r_b_vld;
    logic signed [ACC_W-1:0]        r_b_acc;
    logic [NUM_SLOTS-1:0][SMP_W-1:0] r_b_smp;
    logic [NUM_SLOTS-1:0]           r_b_en;

    logic                           w_rdy_a;
    logic                           w_rdy_b;
    logic signed [PROD_W-1:0]       n_prod;
    logic signed [SUM_W-1:0]        w_x;
    logic                           w_fix;
    logic signed [ACC_W-1:0]        n_acc;

    assign w_rdy_b = !r_b_vld || i_ready;
    assign w_rdy_a = !r_a_vld || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_comb begin
        if (i_en[SLOT]) begin
            n_prod = PROD_W'($signed(i_smp[SLOT])) * PROD_W'($signed({1'b0, i_weight}));
        end else begin
            n_prod = '0;
        end
    end

    // acc*65536 + prod, then divide by 65536 rounding toward zero
    assign w_x = {{(SUM_W-ACC_W-FRAC_W){r_a_acc[ACC_W-1]}}, r_a_acc, {FRAC_W{1'b0}}}
               + {{(SUM_W-PROD_W){r_a_prod[PROD_W-1]}}, r_a_prod};
    assign w_fix = w_x[SUM_W-1] && (w_x[FRAC_W-1:0] != '0);
    assign n_acc = w_x[ACC_W+FRAC_W-1:FRAC_W] + ACC_W'(w_fix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_vld <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy_a) begin
            r_a_acc  <= i_acc;
            r_a_prod <= n_prod;
            r_a_smp  <= i_smp;
            r_a_en   <= i_en;
        end
        if (r_a_vld && w_rdy_b) begin
            r_b_acc <= n_acc;
            r_b_smp <= r_a_smp;
            r_b_en  <= r_a_en;
        end
    end

    assign o_valid = r_b_vld;
    assign o_acc   = r_b_acc;
    assign o_smp   = r_b_smp;
    assign o_en    = r_b_en;

endmodule

// ===== hdl/wam_sat.sv =====
module wam_sat (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [wam_pkg::ACC_W-1:0] i_acc,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [wam_pkg::SMP_W-1:0] o_data
);
    import wam_pkg::*;

    logic                    r_vld;
    logic signed [SMP_W-1:0] r_data;
    logic signed [SMP_W-1:0] n_data;
    logic                    w_rdy;

    assign w_rdy   = !r_vld || i_ready;
    assign o_ready = w_rdy;

    always_comb begin
        if (i_acc > SAT_MAX) begin
            n_data = SAT_MAX[SMP_W-1:0];
        end else if (i_acc < SAT_MIN) begin
            n_data = SAT_MIN[SMP_W-1:0];
        end else begin
            n_data = i_acc[SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

// ===== hdl/wam_chk.sv =====
module wam_chk #(
    parameter int MAX_SOURCES = 4
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [wam_pkg::SMP_W-1:0]     o_mixed_sample
);
    import wam_pkg::*;

    localparam int NUM_SLOTS = (MAX_SOURCES < FIELDS) ? MAX_SOURCES : FIELDS;
    localparam int DEPTH     = 2 * NUM_SLOTS + 1;
    localparam int LVL_W     = $clog2(DEPTH + 2);

    logic [LVL_W-1:0] r_lvl;
    logic             w_in_xfer;
    logic             w_out_xfer;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;

    // items inside the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else begin
            r_lvl <= r_lvl + LVL_W'(w_in_xfer) - LVL_W'(w_out_xfer);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mixed_sample))
        else $error("output transfer dropped or changed while stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl == '0 |-> !o_out_valid)
        else $error("result presented with no item in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= LVL_W'(DEPTH))
        else $error("more items in flight than pipeline stages");

endmodule

bind weighted_audio_mixer_top wam_chk #(
    .MAX_SOURCES (MAX_SOURCES)
) u_wam_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_mixed_sample (o_mixed_sample)
);
